FILE: design/rbsi_pkg.sv
package rbsi_pkg;

   // default field format
   localparam int COORD_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;

   // quotient bits kept by each divider; enough to exceed any max_distance
   localparam int Q_WIDTH    = 32;
   // slab distance, signed, range -1 .. max_distance + 1
   localparam int T_WIDTH    = Q_WIDTH + 1;
   localparam int DIST_WIDTH = 31;

   // configuration port
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_INDEX_LSB  = 2;
   localparam logic REG_MAX_DISTANCE = 1'b0;

   localparam logic [DIST_WIDTH-1:0] MAX_DISTANCE_RESET = '1;

   // what one axis hands to the merge stage
   typedef struct packed {
      logic signed [T_WIDTH-1:0] t_lo;
      logic signed [T_WIDTH-1:0] t_hi;
      logic                      ok;
   } lane_result_type;

endpackage

FILE: design/rbsi_divider.sv
// Pipelined restoring divider, one quotient bit per stage.
// q = floor((nmag << FRAC_BITS) / dmag), saturated to all ones on overflow.
module rbsi_divider #(
   parameter int COORD_WIDTH = rbsi_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = rbsi_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          enable,
   input  logic [COORD_WIDTH-1:0]        nmag,
   input  logic [COORD_WIDTH-1:0]        dmag,
   output logic [rbsi_pkg::Q_WIDTH-1:0]  quotient
);
   import rbsi_pkg::*;

   localparam int DW = COORD_WIDTH + FRAC_BITS;
   localparam int EW = DW + Q_WIDTH;

   logic [EW-1:0] ext;
   logic [DW-1:0] upper;

   logic [COORD_WIDTH-1:0] rem_ff  [Q_WIDTH+1];
   logic [COORD_WIDTH-1:0] dmag_ff [Q_WIDTH+1];
   logic [Q_WIDTH-1:0]     low_ff  [Q_WIDTH+1];
   logic [Q_WIDTH-1:0]     q_ff    [Q_WIDTH+1];
   logic                   ovf_ff  [Q_WIDTH+1];

   // dividend split: high part seeds the remainder, low word shifts in
   assign ext   = {{Q_WIDTH{1'b0}}, nmag, {FRAC_BITS{1'b0}}};
   assign upper = ext[EW-1:Q_WIDTH];

   always_ff @(posedge clock) begin
      if (enable) begin
         ovf_ff[0]  <= upper >= {{FRAC_BITS{1'b0}}, dmag};
         rem_ff[0]  <= upper[COORD_WIDTH-1:0];
         low_ff[0]  <= ext[Q_WIDTH-1:0];
         dmag_ff[0] <= dmag;
         q_ff[0]    <= '0;
      end
   end

   for (genvar s = 0; s < Q_WIDTH; s++) begin : g_stage
      logic [COORD_WIDTH:0] trial;
      logic [COORD_WIDTH:0] diff;
      logic                 ge;

      assign trial = {rem_ff[s], low_ff[s][Q_WIDTH-1]};
      assign diff  = trial - {1'b0, dmag_ff[s]};
      assign ge    = trial >= {1'b0, dmag_ff[s]};

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[s+1]  <= ge ? diff[COORD_WIDTH-1:0] : trial[COORD_WIDTH-1:0];
            low_ff[s+1]  <= {low_ff[s][Q_WIDTH-2:0], 1'b0};
            q_ff[s+1]    <= {q_ff[s][Q_WIDTH-2:0], ge};
            dmag_ff[s+1] <= dmag_ff[s];
            ovf_ff[s+1]  <= ovf_ff[s];
         end
      end
   end

   assign quotient = ovf_ff[Q_WIDTH] ? {Q_WIDTH{1'b1}} : q_ff[Q_WIDTH];

endmodule

FILE: design/rbsi_lane.sv
// One axis: slab plane distances, clamped, signed and put in order.
module rbsi_lane #(
   parameter int COORD_WIDTH = rbsi_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = rbsi_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 enable,
   input  logic signed [COORD_WIDTH-1:0]        origin,
   input  logic signed [COORD_WIDTH-1:0]        direction,
   input  logic signed [COORD_WIDTH-1:0]        box_min,
   input  logic signed [COORD_WIDTH-1:0]        box_max,
   input  logic [rbsi_pkg::Q_WIDTH-1:0]         cap,
   output rbsi_pkg::lane_result_type            result
);
   import rbsi_pkg::*;

   localparam int DELAY = Q_WIDTH + 1;

   typedef struct packed {
      logic neg_min;
      logic neg_max;
      logic dzero;
      logic in_slab;
   } side_type;

   logic signed [COORD_WIDTH:0] diff_min, diff_max;
   logic                        nneg_min, nneg_max, dneg;
   logic [COORD_WIDTH-1:0]      dmag_in;

   logic [COORD_WIDTH-1:0] nmag_min_ff, nmag_max_ff, dmag_ff;
   side_type               side_ff [DELAY+1];
   logic [Q_WIDTH-1:0]     q_min, q_max;

   logic signed [T_WIDTH-1:0] t1_in, t2_in, t1_ff, t2_ff;
   logic                      ok_ff;
   lane_result_type           result_ff;

   // operand prep: magnitudes and signs
   assign diff_min = $signed({box_min[COORD_WIDTH-1], box_min}) -
                     $signed({origin[COORD_WIDTH-1], origin});
   assign diff_max = $signed({box_max[COORD_WIDTH-1], box_max}) -
                     $signed({origin[COORD_WIDTH-1], origin});
   assign nneg_min = diff_min[COORD_WIDTH];
   assign nneg_max = diff_max[COORD_WIDTH];
   assign dneg     = direction[COORD_WIDTH-1];
   assign dmag_in  = dneg ? COORD_WIDTH'(-direction) : COORD_WIDTH'(direction);

   always_ff @(posedge clock) begin
      if (enable) begin
         nmag_min_ff        <= nneg_min ? COORD_WIDTH'(-diff_min) : diff_min[COORD_WIDTH-1:0];
         nmag_max_ff        <= nneg_max ? COORD_WIDTH'(-diff_max) : diff_max[COORD_WIDTH-1:0];
         dmag_ff            <= (direction == '0) ? COORD_WIDTH'(1) : dmag_in;
         side_ff[0].neg_min <= nneg_min ^ dneg;
         side_ff[0].neg_max <= nneg_max ^ dneg;
         side_ff[0].dzero   <= direction == '0;
         side_ff[0].in_slab <= (box_min <= origin) && (origin <= box_max);
      end
   end

   rbsi_divider #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div_min (
      .clock(clock), .enable(enable), .nmag(nmag_min_ff), .dmag(dmag_ff),
      .quotient(q_min)
   );

   rbsi_divider #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div_max (
      .clock(clock), .enable(enable), .nmag(nmag_max_ff), .dmag(dmag_ff),
      .quotient(q_max)
   );

   // flags ride alongside the dividers
   for (genvar s = 0; s < DELAY; s++) begin : g_side
      always_ff @(posedge clock) begin
         if (enable) begin
            side_ff[s+1] <= side_ff[s];
         end
      end
   end

   // clamp to cap, apply sign; zero direction leaves the interval alone
   function automatic logic signed [T_WIDTH-1:0] to_t(
      input logic [Q_WIDTH-1:0] q, input logic [Q_WIDTH-1:0] c, input logic neg);
      logic [Q_WIDTH-1:0] nq;
      nq = (q > c) ? c : q;
      if (neg) begin
         to_t = (nq != '0) ? -T_WIDTH'(1) : '0;
      end else begin
         to_t = $signed({1'b0, nq});
      end
   endfunction

   always_comb begin
      if (side_ff[DELAY].dzero) begin
         t1_in = -T_WIDTH'(1);
         t2_in = $signed({1'b0, cap});
      end else begin
         t1_in = to_t(q_min, cap, side_ff[DELAY].neg_min);
         t2_in = to_t(q_max, cap, side_ff[DELAY].neg_max);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         t1_ff <= t1_in;
         t2_ff <= t2_in;
         ok_ff <= !side_ff[DELAY].dzero || side_ff[DELAY].in_slab;
      end
   end

   // put entry and exit in order
   always_ff @(posedge clock) begin
      if (enable) begin
         result_ff.t_lo <= (t1_ff > t2_ff) ? t2_ff : t1_ff;
         result_ff.t_hi <= (t1_ff > t2_ff) ? t1_ff : t2_ff;
         result_ff.ok   <= ok_ff;
      end
   end

   assign result = result_ff;

endmodule

FILE: design/rbsi_merge.sv
// Intersects the three slab intervals with [0, max_distance].
module rbsi_merge (
   input  logic                                 clock,
   input  logic                                 enable,
   input  rbsi_pkg::lane_result_type            lane_x,
   input  rbsi_pkg::lane_result_type            lane_y,
   input  rbsi_pkg::lane_result_type            lane_z,
   input  logic [rbsi_pkg::DIST_WIDTH-1:0]      max_distance,
   output logic                                 hit,
   output logic [rbsi_pkg::DIST_WIDTH-1:0]      distance
);
   import rbsi_pkg::*;

   logic signed [T_WIDTH-1:0] lo_in, hi_in, lo_ff, hi_ff;
   logic                      ok_ff, hit_ff;
   logic [DIST_WIDTH-1:0]     distance_ff;

   // running interval over the lanes
   always_comb begin
      lo_in = '0;
      hi_in = $signed({2'b00, max_distance});
      if (lane_x.t_lo > lo_in) lo_in = lane_x.t_lo;
      if (lane_y.t_lo > lo_in) lo_in = lane_y.t_lo;
      if (lane_z.t_lo > lo_in) lo_in = lane_z.t_lo;
      if (lane_x.t_hi < hi_in) hi_in = lane_x.t_hi;
      if (lane_y.t_hi < hi_in) hi_in = lane_y.t_hi;
      if (lane_z.t_hi < hi_in) hi_in = lane_z.t_hi;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
         ok_ff <= lane_x.ok && lane_y.ok && lane_z.ok;
      end
   end

   // empty interval is a miss
   always_ff @(posedge clock) begin
      if (enable) begin
         hit_ff      <= ok_ff && !(lo_ff > hi_ff);
         distance_ff <= (ok_ff && !(lo_ff > hi_ff)) ? lo_ff[DIST_WIDTH-1:0] : '0;
      end
   end

   assign hit      = hit_ff;
   assign distance = distance_ff;

endmodule

FILE: design/ray_box_slab_intersect.sv
// Ray / axis-aligned box test by the slab method in signed fixed point.
// One word (ray origin, direction, box corners) is taken every cycle unless
// stalled, and one result word (hit, entry distance) leaves for each.
// Its core is the six pipelined restoring dividers, two per axis lane, each
// producing one quotient bit per stage. A stall on a waiting result word
// holds the whole pipeline and is passed back on req_stall. max_distance
// (register 0, byte address 0) bounds the interval; write it only while
// the pipeline is empty.
module ray_box_slab_intersect #(
   parameter int COORD_WIDTH = rbsi_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = rbsi_pkg::FRAC_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [COORD_WIDTH-1:0]          req_origin_x,
   input  logic signed [COORD_WIDTH-1:0]          req_origin_y,
   input  logic signed [COORD_WIDTH-1:0]          req_origin_z,
   input  logic signed [COORD_WIDTH-1:0]          req_direction_x,
   input  logic signed [COORD_WIDTH-1:0]          req_direction_y,
   input  logic signed [COORD_WIDTH-1:0]          req_direction_z,
   input  logic signed [COORD_WIDTH-1:0]          req_box_min_x,
   input  logic signed [COORD_WIDTH-1:0]          req_box_min_y,
   input  logic signed [COORD_WIDTH-1:0]          req_box_min_z,
   input  logic signed [COORD_WIDTH-1:0]          req_box_max_x,
   input  logic signed [COORD_WIDTH-1:0]          req_box_max_y,
   input  logic signed [COORD_WIDTH-1:0]          req_box_max_z,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_hit,
   output logic [rbsi_pkg::DIST_WIDTH-1:0]        rsp_distance,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [rbsi_pkg::CSR_ADDR_WIDTH-1:0]    csr_paddr,
   input  logic [rbsi_pkg::CSR_DATA_WIDTH-1:0]    csr_pwdata,
   output logic [rbsi_pkg::CSR_DATA_WIDTH-1:0]    csr_prdata,
   output logic                                   csr_pready
);
   import rbsi_pkg::*;

   localparam int LATENCY = Q_WIDTH + 6;

   logic                  enable;
   logic [DIST_WIDTH-1:0] max_distance_ff, max_distance_in;
   logic [LATENCY-1:0]    valid_ff, valid_in;
   logic [Q_WIDTH-1:0]    cap;
   lane_result_type       res_x, res_y, res_z;

   // pipeline moves unless a finished word is held
   assign enable    = !(rsp_valid && rsp_stall);
   assign req_stall = !enable;

   // register file
   always_comb begin
      max_distance_in = max_distance_ff;
      if (csr_psel && csr_penable && csr_pwrite &&
          csr_paddr[CSR_INDEX_LSB] == REG_MAX_DISTANCE) begin
         max_distance_in = csr_pwdata[DIST_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_distance_ff <= MAX_DISTANCE_RESET;
      end else begin
         max_distance_ff <= max_distance_in;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[CSR_INDEX_LSB] == REG_MAX_DISTANCE) ?
                       CSR_DATA_WIDTH'(max_distance_ff) : '0;

   assign cap = Q_WIDTH'(max_distance_ff) + Q_WIDTH'(1);

   // valid tracking
   assign valid_in = enable ? {valid_ff[LATENCY-2:0], req_valid} : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff[LATENCY-1];

   rbsi_lane #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_lane_x (
      .clock(clock), .enable(enable), .origin(req_origin_x),
      .direction(req_direction_x), .box_min(req_box_min_x),
      .box_max(req_box_max_x), .cap(cap), .result(res_x)
   );

   rbsi_lane #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_lane_y (
      .clock(clock), .enable(enable), .origin(req_origin_y),
      .direction(req_direction_y), .box_min(req_box_min_y),
      .box_max(req_box_max_y), .cap(cap), .result(res_y)
   );

   rbsi_lane #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_lane_z (
      .clock(clock), .enable(enable), .origin(req_origin_z),
      .direction(req_direction_z), .box_min(req_box_min_z),
      .box_max(req_box_max_z), .cap(cap), .result(res_z)
   );

   rbsi_merge u_merge (
      .clock(clock), .enable(enable), .lane_x(res_x), .lane_y(res_y),
      .lane_z(res_z), .max_distance(max_distance_ff), .hit(rsp_hit),
      .distance(rsp_distance)
   );

endmodule

FILE: sim/ray_box_slab_intersect_tb.sv
module ray_box_slab_intersect_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rbsi_pkg::*;

   localparam int CW = 32;
   localparam int FB = 16;
   localparam int LATENCY = Q_WIDTH + 6;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int N_RANDOM = 2000;

   typedef logic signed [CW-1:0] coord_t;

   // one ray/box word: origin, direction, box min, box max (x, y, z each)
   typedef struct {
      coord_t org [3];
      coord_t dir [3];
      coord_t bmin [3];
      coord_t bmax [3];
   } ray_box_t;

   typedef struct {
      logic                  hit;
      logic [DIST_WIDTH-1:0] distance;
   } hit_result_t;

   // directed row: word plus optional typed-in result
   typedef struct {
      ray_box_t              rb;
      bit                    known;
      logic                  hit;
      logic [DIST_WIDTH-1:0] distance;
   } directed_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   coord_t req_org [3];
   coord_t req_dir [3];
   coord_t req_bmin [3];
   coord_t req_bmax [3];
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_hit;
   logic [DIST_WIDTH-1:0] rsp_distance;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic csr_pready;

   logic [DIST_WIDTH-1:0] max_dist_shadow;
   hit_result_t expected_hits [$];
   int errors = 0;
   int idle_cycles = 0;
   bit stim_done = 1'b0;

   initial begin
      for (int a = 0; a < 3; a++) begin
         req_org[a] = '0;
         req_dir[a] = '0;
         req_bmin[a] = '0;
         req_bmax[a] = '0;
      end
   end

   always #5 clock = ~clock;

   ray_box_slab_intersect DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_origin_x(req_org[0]), .req_origin_y(req_org[1]), .req_origin_z(req_org[2]),
      .req_direction_x(req_dir[0]), .req_direction_y(req_dir[1]),
      .req_direction_z(req_dir[2]),
      .req_box_min_x(req_bmin[0]), .req_box_min_y(req_bmin[1]), .req_box_min_z(req_bmin[2]),
      .req_box_max_x(req_bmax[0]), .req_box_max_y(req_bmax[1]), .req_box_max_z(req_bmax[2]),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_hit(rsp_hit), .rsp_distance(rsp_distance),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // slab distance (c - o) / d with FB fraction bits, truncated, clamped to [-1, cap]
   function automatic longint slab_distance(coord_t c, coord_t o, coord_t d, longint cap);
      logic signed [CW:0] num;
      logic [CW:0] nmag;
      logic [CW-1:0] dmag;
      logic [CW+FB:0] scaled;
      logic [CW+FB:0] q;
      bit neg;
      longint qv;
      num = {c[CW-1], c} - {o[CW-1], o};
      nmag = num[CW] ? -num : num;
      dmag = d[CW-1] ? -d : d;
      neg = num[CW] != d[CW-1];
      scaled = {nmag, {FB{1'b0}}};
      q = scaled / dmag;
      if (q > cap) qv = cap;
      else qv = longint'(q);
      if (neg) return (qv > 0) ? -1 : 0;
      return qv;
   endfunction

   function automatic hit_result_t predict_hit(ray_box_t rb, logic [DIST_WIDTH-1:0] maxd);
      hit_result_t r;
      longint near_t, far_t, t1, t2, s, cap;
      bit ok;
      near_t = 0;
      far_t = maxd;
      cap = longint'(maxd) + 1;
      ok = 1'b1;
      for (int a = 0; a < 3; a++) begin
         if (rb.dir[a] == 0) begin
            if (!(rb.bmin[a] <= rb.org[a] && rb.org[a] <= rb.bmax[a])) ok = 1'b0;
         end else begin
            t1 = slab_distance(rb.bmin[a], rb.org[a], rb.dir[a], cap);
            t2 = slab_distance(rb.bmax[a], rb.org[a], rb.dir[a], cap);
            if (t1 > t2) begin
               s = t1; t1 = t2; t2 = s;
            end
            if (t1 > near_t) near_t = t1;
            if (t2 < far_t) far_t = t2;
         end
      end
      if (near_t > far_t) ok = 1'b0;
      r.hit = ok;
      r.distance = ok ? near_t[DIST_WIDTH-1:0] : '0;
      return r;
   endfunction

   function automatic coord_t rand_coord();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
         2: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         3: return $signed($urandom_range(0, 8)) - 4;
         default: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
      endcase
   endfunction

   // mostly well-formed boxes with a random ray, some axes with random corners
   function automatic ray_box_t rand_ray_box();
      ray_box_t rb;
      coord_t lo, hi, span;
      for (int a = 0; a < 3; a++) begin
         rb.org[a] = rand_coord();
         rb.dir[a] = ($urandom_range(0, 9) == 0) ? coord_t'(0) : rand_coord();
         if ($urandom_range(0, 4) == 0) begin
            rb.bmin[a] = rand_coord();
            rb.bmax[a] = rand_coord();
         end else begin
            lo = $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
            span = $urandom_range(0, 32'h00FF_FFFF);
            hi = lo + span;
            rb.bmin[a] = lo;
            rb.bmax[a] = hi;
            if ($urandom_range(0, 3) == 0) rb.org[a] = lo + $urandom_range(0, span);
         end
      end
      return rb;
   endfunction

   task automatic csr_write(int index, logic [CSR_DATA_WIDTH-1:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_WIDTH'(4 * index);
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (index == int'(REG_MAX_DISTANCE)) max_dist_shadow = value[DIST_WIDTH-1:0];
   endtask

   // valid drops only when this word draws idle cycles; callers that
   // pause the sender drop it themselves
   task automatic send_word(ray_box_t rb, bit known, hit_result_t typed);
      hit_result_t r;
      int n;
      n = $urandom_range(0, 3);
      if (n != 0) begin
         req_valid <= 1'b0;
         repeat (n) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_org <= rb.org;
      req_dir <= rb.dir;
      req_bmin <= rb.bmin;
      req_bmax <= rb.bmax;
      do @(posedge clock); while (req_stall);
      r = known ? typed : predict_hit(rb, max_dist_shadow);
      expected_hits.push_back(r);
      @(negedge clock);
   endtask

   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (expected_hits.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   function automatic ray_box_t mk(coord_t ox, coord_t oy, coord_t oz,
                                   coord_t dx, coord_t dy, coord_t dz,
                                   coord_t lx, coord_t ly, coord_t lz,
                                   coord_t hx, coord_t hy, coord_t hz);
      ray_box_t rb;
      rb.org = '{ox, oy, oz};
      rb.dir = '{dx, dy, dz};
      rb.bmin = '{lx, ly, lz};
      rb.bmax = '{hx, hy, hz};
      return rb;
   endfunction

   localparam coord_t ONE = 32'sh0001_0000;
   localparam coord_t CMAX = 32'sh7FFF_FFFF;
   localparam coord_t CMIN = 32'sh8000_0000;

   // result checker
   always @(posedge clock) begin
      hit_result_t e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_hits.size() == 0) begin
            $error("unexpected result word hit=%0d distance=%0h", rsp_hit, rsp_distance);
            errors++;
         end else begin
            e = expected_hits.pop_front();
            if (rsp_hit !== e.hit) begin
               $error("hit: expected %0d actual %0d", e.hit, rsp_hit);
               errors++;
            end
            if (rsp_distance !== e.distance) begin
               $error("distance: expected %0h actual %0h", e.distance, rsp_distance);
               errors++;
            end
         end
      end
   end

   // result-side stall in random bursts between unstalled cycles
   initial begin
      int n;
      @(negedge clock);
      forever begin
         n = $urandom_range(0, 3);
         if ($urandom_range(0, 7) == 0) n = 0;
         if (n != 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(negedge clock);
      end
   end

   // watchdog on cycles with no accepted word
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || stim_done)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("ray_box_slab_intersect_tb failed");
         $finish;
      end
   end

   initial begin
      directed_row_t rows [$];
      directed_row_t row;
      hit_result_t typed;
      int settings [4];
      int wait_cycles;
      max_dist_shadow = MAX_DISTANCE_RESET;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ray along +x from origin into the box at x=2..3: enters at 2.0
      row.rb = mk(0, 0, 0, ONE, 0, 0, 2*ONE, -ONE, -ONE, 3*ONE, ONE, ONE);
      row.known = 1'b1; row.hit = 1'b1; row.distance = DIST_WIDTH'(2*ONE); rows.push_back(row);
      // box behind the ray: miss
      row.rb = mk(0, 0, 0, ONE, 0, 0, -3*ONE, -ONE, -ONE, -2*ONE, ONE, ONE);
      row.known = 1'b1; row.hit = 1'b0; row.distance = '0; rows.push_back(row);
      // zero direction with origin outside the slab: miss
      row.rb = mk(0, 5*ONE, 0, ONE, 0, 0, 2*ONE, -ONE, -ONE, 3*ONE, ONE, ONE);
      row.known = 1'b1; row.hit = 1'b0; row.distance = '0; rows.push_back(row);
      // origin inside the box: distance 0
      row.rb = mk(0, 0, 0, ONE, ONE, ONE, -ONE, -ONE, -ONE, ONE, ONE, ONE);
      row.known = 1'b1; row.hit = 1'b1; row.distance = '0; rows.push_back(row);
      // all directions zero, origin on the box faces
      row.rb = mk(ONE, ONE, ONE, 0, 0, 0, ONE, -ONE, -ONE, ONE, ONE, ONE);
      row.known = 1'b1; row.hit = 1'b1; row.distance = '0; rows.push_back(row);
      // zero direction with swapped corners: miss
      row.rb = mk(0, 0, 0, 0, ONE, 0, ONE, -ONE, -ONE, -ONE, ONE, ONE);
      row.known = 1'b1; row.hit = 1'b0; row.distance = '0; rows.push_back(row);
      row.known = 1'b0;
      // swapped corners, nonzero direction
      row.rb = mk(0, 0, 0, -ONE, 0, 0, -2*ONE, ONE, ONE, -5*ONE, -ONE, -ONE); rows.push_back(row);
      // extremes of every field
      row.rb = mk(CMIN, CMIN, CMIN, 1, 1, 1, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX); rows.push_back(row);
      row.rb = mk(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX); rows.push_back(row);
      row.rb = mk(CMAX, CMIN, 0, CMAX, -1, CMIN, CMIN, CMAX, -1, CMAX, CMIN, 1); rows.push_back(row);
      row.rb = mk(-1, -1, -1, -1, -1, -1, CMIN, CMIN, CMIN, -1, -1, -1); rows.push_back(row);
      row.rb = mk(0, 0, 0, 1, -1, 1, ONE, ONE, -ONE, 2*ONE, 2*ONE, ONE); rows.push_back(row);
      // tiny negative quotient truncates to zero
      row.rb = mk(ONE, 0, 0, CMAX, 0, 0, ONE - 1, -ONE, -ONE, 4*ONE, ONE, ONE); rows.push_back(row);

      foreach (rows[i]) begin
         typed.hit = rows[i].hit;
         typed.distance = rows[i].distance;
         send_word(rows[i].rb, rows[i].known, typed);
      end
      drain_pipeline();

      // random phases across several max_distance settings
      settings = '{2*ONE, 0, 1, 32'h7FFF_FFFF};
      for (int p = 0; p < 4; p++) begin
         csr_write(int'(REG_MAX_DISTANCE), settings[p]);
         for (int i = 0; i < N_RANDOM / 4; i++) begin
            typed = '{default: '0};
            send_word(rand_ray_box(), 0, typed);
            // hold off until the pipe is empty once mid-phase
            if (i == N_RANDOM / 8) begin
               req_valid <= 1'b0;
               while (expected_hits.size() != 0) @(negedge clock);
            end
         end
         drain_pipeline();
      end
      // also exercise the top config bit through a full write word
      csr_write(int'(REG_MAX_DISTANCE), 32'hFFFF_FFFF);
      for (int i = 0; i < 20; i++) send_word(rand_ray_box(), 0, typed);
      req_valid <= 1'b0;

      wait_cycles = 0;
      while (expected_hits.size() != 0 && wait_cycles < 100 * LATENCY) begin
         @(negedge clock);
         wait_cycles++;
      end
      stim_done = 1'b1;
      repeat (LATENCY + 4) @(negedge clock);
      if (expected_hits.size() != 0) begin
         $error("%0d result words never arrived", expected_hits.size());
         errors++;
      end
      if (errors == 0)
         $display("ray_box_slab_intersect_tb passed");
      else
         $display("ray_box_slab_intersect_tb failed");
      $finish;
   end
endmodule

FILE: filelist.f
design/rbsi_pkg.sv
design/rbsi_divider.sv
design/rbsi_lane.sv
design/rbsi_merge.sv
design/ray_box_slab_intersect.sv
sim/ray_box_slab_intersect_tb.sv
